// ===== hdl/periodic_task_tick_scheduler_core_macros.svh =====
// assertion macros for the periodic task tick scheduler
`ifndef PERIODIC_TASK_TICK_SCHEDULER_CORE_MACROS_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// checked outside reset
`define PTTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("scheduler assertion failed");

// checked on every edge, reset included
`define PTTS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("scheduler assertion failed");

`else

`define PTTS_ASSERT(lbl, prop)
`define PTTS_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== hdl/ptts_pkg.sv =====
// types and constants shared by the periodic task tick scheduler
`timescale 1ns / 1ps

package ptts_pkg;

  localparam int CMD_W    = 3;
  localparam int IDX_W    = 3;
  localparam int PERIOD_W = 16;
  localparam int DELAY_W  = 8;
  localparam int MASK_W   = 8;
  localparam int SLOT_EXT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_CREATE  = 3'd1,
    CMD_DELETE  = 3'd2,
    CMD_SUSPEND = 3'd3,
    CMD_RESUME  = 3'd4
  } command_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD_READ,
    S_CMD_WRITE,
    S_TICK,
    S_TICK_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic                present;
    logic                resumed;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] countdown;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic we;
    logic status;
    logic fire;
  } alu_res_t;

endpackage

// ===== hdl/ptts_if.sv =====
// request and response channel interfaces
`timescale 1ns / 1ps

interface ptts_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [2:0]  task_index;
  logic [15:0] period;
  logic [7:0]  first_delay;

  modport source (output valid, command, task_index, period, first_delay, input ready);
  modport sink   (input valid, command, task_index, period, first_delay, output ready);
endinterface

interface ptts_rsp_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] fire_mask;

  modport source (output valid, status, fire_mask, input ready);
  modport sink   (input valid, status, fire_mask, output ready);
endinterface

// ===== hdl/ptts_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module ptts_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/ptts_slot_alu.sv =====
// read-modify-write update of one task slot
`timescale 1ns / 1ps

module ptts_slot_alu (
  input  ptts_pkg::command_t             cmd,
  input  ptts_pkg::entry_t               cur,
  input  logic [ptts_pkg::PERIOD_W-1:0]  period,
  input  logic [ptts_pkg::DELAY_W-1:0]   first_delay,
  output ptts_pkg::entry_t               nxt,
  output ptts_pkg::alu_res_t             res
);

  import ptts_pkg::*;

  always_comb begin
    nxt = cur;
    res = '0;
    case (cmd)
      CMD_TICK: begin
        if (cur.resumed) begin
          if (cur.countdown != '0) begin
            nxt.countdown = cur.countdown - PERIOD_W'(1);
            res.we = 1'b1;
          end else if (cur.present) begin
            nxt.countdown = cur.period;
            res.fire = 1'b1;
            res.we = 1'b1;
          end
        end
      end
      CMD_CREATE: begin
        if (cur.present) begin
          res.status = 1'b1;
        end else begin
          nxt.present   = 1'b1;
          nxt.resumed   = 1'b1;
          nxt.period    = period;
          nxt.countdown = PERIOD_W'(first_delay);
          res.we = 1'b1;
        end
      end
      CMD_DELETE: begin
        nxt.present = 1'b0;
        res.we = 1'b1;
      end
      CMD_SUSPEND: begin
        nxt.resumed = 1'b0;
        res.we = 1'b1;
      end
      CMD_RESUME: begin
        nxt.resumed = 1'b1;
        res.we = 1'b1;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// ===== hdl/periodic_task_tick_scheduler_core.sv =====
// Periodic task tick scheduler top level. The task table lives in one
// synchronous RAM of TASK_SLOTS entries (present, resumed, period, countdown),
// with a valid flop per entry so that entries never written read as an empty
// slot straight after reset; no clearing pass is needed. Create, delete,
// suspend and resume go from accepted beat to result through one read, one
// write-back and one output load. A tick walks the slots through the single
// RAM read port, one slot per cycle with the write-back of a slot overlapping
// the read of the next. Out-of-range slot indexes and unknown commands answer
// with a zero result. One beat is worked at a time; a finished result waits
// in the output register while the next beat is accepted and worked.
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_core #(
  parameter int TASK_SLOTS = 8
) (
  input logic       clk,
  input logic       rst,
  ptts_req_if.sink  req,
  ptts_rsp_if.source rsp
);

  import ptts_pkg::*;

  `include "periodic_task_tick_scheduler_core_macros.svh"

  localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

  state_t state;
  state_t state_next;

  command_t            cmd_q;
  logic [PERIOD_W-1:0] period_q;
  logic [DELAY_W-1:0]  delay_q;
  logic [SLOT_W-1:0]   ptr;
  logic [SLOT_W-1:0]   wb_slot;
  logic                wb_pend;
  logic                status_q;
  logic [MASK_W-1:0]   mask_q;
  logic [MASK_W-1:0]   fire_bits;
  logic [TASK_SLOTS-1:0] entry_valid;
  logic                rd_valid_q;

  logic                out_valid;
  logic                out_status;
  logic [MASK_W-1:0]   out_mask;

  logic                rd_en;
  logic [SLOT_W-1:0]   rd_addr;
  logic                proc;
  logic [ENTRY_W-1:0]  rdata;
  entry_t              cur;
  entry_t              nxt;
  alu_res_t            res;
  logic                ram_we;
  logic                accept;
  logic                out_free;
  command_t            req_cmd;
  logic [SLOT_EXT_W-1:0] idx_ext;
  logic                idx_ok;
  logic [SLOT_EXT_W-1:0] wb_slot_ext;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign req_cmd  = command_t'(req.command);
  assign idx_ext  = SLOT_EXT_W'(req.task_index);
  assign idx_ok   = idx_ext < SLOT_EXT_W'(TASK_SLOTS);
  assign wb_slot_ext = SLOT_EXT_W'(wb_slot);

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.fire_mask = out_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en = 1'b0;
    rd_addr = wb_slot;
    proc = 1'b0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req_cmd == CMD_TICK) begin
            state_next = S_TICK;
          end else if (idx_ok && req_cmd inside {CMD_CREATE, CMD_DELETE,
                                                 CMD_SUSPEND, CMD_RESUME}) begin
            state_next = S_CMD_READ;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_CMD_READ: begin
        rd_en = 1'b1;
        state_next = S_CMD_WRITE;
      end
      S_CMD_WRITE: begin
        proc = 1'b1;
        state_next = S_FINISH;
      end
      S_TICK: begin
        rd_en = 1'b1;
        rd_addr = ptr;
        proc = wb_pend;
        if (ptr == LAST_SLOT) begin
          state_next = S_TICK_DRAIN;
        end
      end
      S_TICK_DRAIN: begin
        proc = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // entries never written read as an empty slot
  assign cur = rd_valid_q ? entry_t'(rdata) : '0;
  assign ram_we = proc && res.we;

  ptts_slot_alu u_alu (
    .cmd         (cmd_q),
    .cur         (cur),
    .period      (period_q),
    .first_delay (delay_q),
    .nxt         (nxt),
    .res         (res)
  );

  ptts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TASK_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wb_slot),
    .wdata (ENTRY_W'(nxt)),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_comb begin
    for (int b = 0; b < MASK_W; b++) begin
      fire_bits[b] = proc && res.fire && (wb_slot_ext == SLOT_EXT_W'(b));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      wb_slot <= '0;
      wb_pend <= 1'b0;
      entry_valid <= '0;
      rd_valid_q <= 1'b0;
      status_q <= 1'b0;
      mask_q <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        ptr <= '0;
        wb_slot <= idx_ext[SLOT_W-1:0];
        status_q <= 1'b0;
        mask_q <= '0;
      end
      if (state == S_TICK) begin
        ptr <= ptr + SLOT_W'(1);
        wb_slot <= ptr;
        wb_pend <= 1'b1;
      end else begin
        wb_pend <= 1'b0;
      end
      if (rd_en) begin
        rd_valid_q <= entry_valid[rd_addr];
      end
      if (ram_we) begin
        entry_valid[wb_slot] <= 1'b1;
      end
      if (proc) begin
        status_q <= status_q | res.status;
        mask_q <= mask_q | fire_bits;
      end
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= req_cmd;
      period_q <= req.period;
      delay_q <= req.first_delay;
    end
    if (state == S_FINISH && out_free) begin
      out_status <= status_q;
      out_mask <= mask_q;
    end
  end

  `PTTS_ASSERT(a_mask_only_on_tick, (state == S_FINISH && cmd_q != CMD_TICK) |-> mask_q == '0)
  `PTTS_ASSERT(a_status_only_on_create, (state == S_FINISH && status_q) |-> cmd_q == CMD_CREATE)
  `PTTS_ASSERT(a_tick_rw_apart, (state == S_TICK && wb_pend) |-> wb_slot != ptr)
  `PTTS_ASSERT(a_valid_only_grows, !$past(rst) |-> ($past(entry_valid) & ~entry_valid) == '0)
  `PTTS_ASSERT_ALWAYS(a_no_write_when_idle, (state == S_IDLE || state == S_FINISH) |-> !ram_we)

endmodule

// ===== verif/periodic_task_tick_scheduler_core_test.sv =====
// self-checking testbench for the periodic task tick scheduler, predicted per beat
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_core_test;
  import ptts_pkg::*;

  localparam int SLOTS = 8;
  localparam int RANDOM_BEATS = 500;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam int IDLE_PCT = 20;
  localparam int QUIET_FROM = 200;
  localparam int QUIET_TO = 330;
  localparam int MAX_REPORTS = 20;
  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST = 3'd7;
  localparam logic ST_OK = 1'b0;
  localparam logic ST_TAKEN = 1'b1;

  typedef struct {
    logic [CMD_W-1:0]    op;
    logic [IDX_W-1:0]    slot;
    logic [PERIOD_W-1:0] period;
    logic [DELAY_W-1:0]  delay;
  } sched_cmd_t;

  typedef struct {
    logic              status;
    logic [MASK_W-1:0] fire_mask;
  } sched_outcome_t;

  logic clk = 1'b0;
  logic rst;

  ptts_req_if req_ch ();
  ptts_rsp_if rsp_ch ();

  periodic_task_tick_scheduler_core i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  sched_cmd_t     pending_cmds[$];
  sched_outcome_t awaited_outcomes[$];

  logic                slot_present[SLOTS];
  logic                slot_resumed[SLOTS];
  logic [PERIOD_W-1:0] slot_period[SLOTS];
  logic [PERIOD_W-1:0] slot_countdown[SLOTS];

  int errors = 0;
  int cycles = 0;
  int beats_in = 0;
  int ticks_seen = 0;
  int firings_seen = 0;
  int refused_creates = 0;
  sched_cmd_t next_cmd;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic sched_outcome_t step_table(sched_cmd_t c);
    sched_outcome_t o;
    int s;
    o.status = ST_OK;
    o.fire_mask = '0;
    s = c.slot;
    if (c.op == CMD_TICK) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_resumed[i]) begin
          if (slot_countdown[i] != 0) begin
            slot_countdown[i] = slot_countdown[i] - 1'b1;
          end else if (slot_present[i]) begin
            if (i < MASK_W) o.fire_mask[i] = 1'b1;
            slot_countdown[i] = slot_period[i];
          end
        end
      end
    end else if (s < SLOTS) begin
      case (c.op)
        CMD_CREATE: begin
          if (slot_present[s]) begin
            o.status = ST_TAKEN;
          end else begin
            slot_present[s] = 1'b1;
            slot_resumed[s] = 1'b1;
            slot_period[s] = c.period;
            slot_countdown[s] = PERIOD_W'(c.delay);
          end
        end
        CMD_DELETE: slot_present[s] = 1'b0;
        CMD_SUSPEND: slot_resumed[s] = 1'b0;
        CMD_RESUME: slot_resumed[s] = 1'b1;
        default: ;
      endcase
    end
    return o;
  endfunction

  function automatic void queue_cmd(logic [CMD_W-1:0] op, logic [IDX_W-1:0] slot,
                                    logic [PERIOD_W-1:0] period, logic [DELAY_W-1:0] delay);
    sched_cmd_t c;
    c.op = op;
    c.slot = slot;
    c.period = period;
    c.delay = delay;
    pending_cmds.push_back(c);
  endfunction

  function automatic sched_cmd_t random_cmd();
    sched_cmd_t c;
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 40) c.op = CMD_TICK;
    else if (pick < 60) c.op = CMD_CREATE;
    else if (pick < 70) c.op = CMD_DELETE;
    else if (pick < 80) c.op = CMD_SUSPEND;
    else if (pick < 95) c.op = CMD_RESUME;
    else c.op = CMD_UNUSED_FIRST
                + CMD_W'($urandom_range(CMD_UNUSED_LAST - CMD_UNUSED_FIRST, 0));
    c.slot = IDX_W'($urandom_range(SLOTS - 1, 0));
    c.period = ($urandom_range(9, 0) == 0) ? PERIOD_W'($urandom())
                                           : PERIOD_W'($urandom_range(6, 0));
    c.delay = ($urandom_range(6, 0) == 0) ? DELAY_W'($urandom())
                                          : DELAY_W'($urandom_range(6, 0));
    return c;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (errors < MAX_REPORTS)
      $display("%0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic logic quiet_window();
    return beats_in >= QUIET_FROM && beats_in < QUIET_TO;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (pending_cmds.size() > 0 && (quiet_window() || $urandom_range(99, 0) >= IDLE_PCT)) begin
        next_cmd = pending_cmds.pop_front();
        req_ch.command <= next_cmd.op;
        req_ch.task_index <= next_cmd.slot;
        req_ch.period <= next_cmd.period;
        req_ch.first_delay <= next_cmd.delay;
        req_ch.valid <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // response back-pressure
  always @(posedge clk) begin
    if (rst) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= quiet_window() || ($urandom_range(99, 0) >= IDLE_PCT);
  end

  // monitor: predict on each request beat, check each response beat
  always @(posedge clk) begin
    sched_cmd_t c;
    sched_outcome_t want;
    if (!rst && req_ch.valid && req_ch.ready) begin
      c.op = req_ch.command;
      c.slot = req_ch.task_index;
      c.period = req_ch.period;
      c.delay = req_ch.first_delay;
      awaited_outcomes.push_back(step_table(c));
      beats_in++;
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_outcomes.size() == 0) begin
        report_mismatch("unexpected response beat, fire_mask", rsp_ch.fire_mask, 0);
      end else begin
        want = awaited_outcomes.pop_front();
        if (rsp_ch.status !== want.status) report_mismatch("status", rsp_ch.status, want.status);
        if (rsp_ch.fire_mask !== want.fire_mask)
          report_mismatch("fire_mask", rsp_ch.fire_mask, want.fire_mask);
        if (want.status == ST_TAKEN) refused_creates++;
        if (want.fire_mask != 0) begin
          ticks_seen++;
          firings_seen += $countones(want.fire_mask);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_present[i] = 1'b0;
      slot_resumed[i] = 1'b0;
      slot_period[i] = '0;
      slot_countdown[i] = '0;
    end
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_TICK;
    req_ch.task_index = '0;
    req_ch.period = '0;
    req_ch.first_delay = '0;
    rsp_ch.ready = 1'b0;

    // directed opening
    queue_cmd(CMD_TICK, 3'd0, 16'h0000, 8'h00);
    queue_cmd(CMD_CREATE, 3'd0, 16'h0000, 8'h00);
    queue_cmd(CMD_TICK, 3'd0, 16'h0000, 8'h00);
    queue_cmd(CMD_TICK, 3'd7, 16'hffff, 8'hff);
    queue_cmd(CMD_CREATE, 3'd0, 16'h0003, 8'h01);
    queue_cmd(CMD_CREATE, 3'd7, 16'hffff, 8'hff);
    queue_cmd(CMD_CREATE, 3'd3, 16'h0001, 8'h02);
    queue_cmd(CMD_TICK, 3'd0, 16'h0000, 8'h00);
    queue_cmd(CMD_TICK, 3'd0, 16'h0000, 8'h00);
    queue_cmd(CMD_TICK, 3'd0, 16'h0000, 8'h00);
    queue_cmd(CMD_DELETE, 3'd0, 16'h0000, 8'h00);
    queue_cmd(CMD_TICK, 3'd0, 16'h0000, 8'h00);
    queue_cmd(CMD_SUSPEND, 3'd3, 16'h0000, 8'h00);
    queue_cmd(CMD_TICK, 3'd0, 16'h0000, 8'h00);
    queue_cmd(CMD_TICK, 3'd0, 16'h0000, 8'h00);
    queue_cmd(CMD_RESUME, 3'd3, 16'h0000, 8'h00);
    queue_cmd(CMD_TICK, 3'd0, 16'h0000, 8'h00);
    queue_cmd(CMD_DELETE, 3'd7, 16'h0000, 8'h00);
    queue_cmd(CMD_TICK, 3'd0, 16'h0000, 8'h00);
    queue_cmd(CMD_CREATE, 3'd7, 16'h5555, 8'haa);
    queue_cmd(CMD_UNUSED_FIRST, 3'd7, 16'hffff, 8'hff);
    queue_cmd(CMD_UNUSED_FIRST + 3'd1, 3'd1, 16'haaaa, 8'h55);
    queue_cmd(CMD_UNUSED_LAST, 3'd2, 16'h0000, 8'h00);
    queue_cmd(CMD_CREATE, 3'd5, 16'h0000, 8'h00);
    queue_cmd(CMD_TICK, 3'd0, 16'h0000, 8'h00);
    for (int n = 0; n < RANDOM_BEATS; n++) pending_cmds.push_back(random_cmd());

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_cmds.size() != 0 || req_ch.valid || awaited_outcomes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d command beats: %0d firing ticks, %0d slot firings, %0d creates on a taken slot",
             beats_in, ticks_seen, firings_seen, refused_creates);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
